[design/es_dfc_pkg.sv]
// ----------------------------------------------------------------------------
// es_dfc_pkg
// Shared types and constants of the ES descriptor frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package es_dfc_pkg;

  // size field limits
  localparam int unsigned MAX_SIZE_BYTES = 4;
  localparam int unsigned SIZE_CNT_W     = 3;
  localparam int unsigned SIZE_W         = 28;
  localparam int unsigned PAYLOAD_W      = 29;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TAG   = 3'd1;
  localparam logic [2:0] ST_LENGTH    = 3'd2;
  localparam logic [2:0] ST_FLAGS     = 3'd3;
  localparam logic [2:0] ST_NO_DC     = 3'd4;
  localparam logic [2:0] ST_NO_SL     = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_ES_TAG = 2'd0;
  localparam logic [1:0] REG_DC_TAG = 2'd1;
  localparam logic [1:0] REG_SL_TAG = 2'd2;

  // reset values of the tag registers
  localparam logic [7:0] ES_TAG_RESET = 8'd3;
  localparam logic [7:0] DC_TAG_RESET = 8'd4;
  localparam logic [7:0] SL_TAG_RESET = 8'd6;

  // expected tags handed to the parser
  typedef struct packed {
    logic [7:0] es;
    logic [7:0] dc;
    logic [7:0] sl;
  } tags_t;

  // one result beat
  typedef struct packed {
    logic [2:0]        status;
    logic [15:0]       stream_id;
    logic [8:0]        decoder_config_bytes;
    logic [8:0]        sl_config_bytes;
    logic              junk_at_end;
    logic [SIZE_W-1:0] declared_length;
  } res_t;

endpackage

`default_nettype wire

[design/es_dfc_parser.sv]
// ----------------------------------------------------------------------------
// es_dfc_parser
// Per-byte frame state of one ES descriptor; forms the result on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module es_dfc_parser
  import es_dfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_byte,
  input  wire tags_t      tags,
  output logic            res_valid,
  output res_t            res
);

  // parse phases
  localparam logic [3:0] PH_TAG     = 4'd0;
  localparam logic [3:0] PH_SIZE    = 4'd1;
  localparam logic [3:0] PH_ID_HI   = 4'd2;
  localparam logic [3:0] PH_ID_LO   = 4'd3;
  localparam logic [3:0] PH_FLAGS   = 4'd4;
  localparam logic [3:0] PH_DC_TAG  = 4'd5;
  localparam logic [3:0] PH_DC_LEN  = 4'd6;
  localparam logic [3:0] PH_DC_SKIP = 4'd7;
  localparam logic [3:0] PH_SL_TAG  = 4'd8;
  localparam logic [3:0] PH_SL_LEN  = 4'd9;
  localparam logic [3:0] PH_SL_SKIP = 4'd10;
  localparam logic [3:0] PH_TRAIL   = 4'd11;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = '1;

  logic [3:0]            phase, phase_next;
  logic [SIZE_W-1:0]     size_acc, size_acc_next;
  logic [SIZE_CNT_W-1:0] size_cnt, size_cnt_next;
  logic [PAYLOAD_W-1:0]  payload_cnt, payload_cnt_next;
  logic [15:0]           id_reg, id_reg_next;
  logic [8:0]            skip_rem, skip_rem_next, skip_dec;
  logic [2:0]            first_err, first_err_next;
  logic [8:0]            dc_len, dc_len_next;
  logic [8:0]            sl_len, sl_len_next;
  logic                  junk, junk_next;
  logic                  hard_err;
  logic [2:0]            status_next;

  assign hard_err = (first_err == ST_BAD_TAG) || (first_err == ST_LENGTH);
  assign skip_dec = (skip_rem != 9'd0) ? skip_rem - 9'd1 : skip_rem;

  // next frame state for the byte being taken
  always_comb begin
    phase_next       = phase;
    size_acc_next    = size_acc;
    size_cnt_next    = size_cnt;
    payload_cnt_next = payload_cnt;
    id_reg_next      = id_reg;
    skip_rem_next    = skip_rem;
    first_err_next   = first_err;
    dc_len_next      = dc_len;
    sl_len_next      = sl_len;
    junk_next        = junk;
    if (take && !hard_err) begin
      unique case (phase)
        PH_TAG: begin
          if (byte_in != tags.es) first_err_next = ST_BAD_TAG;
          else phase_next = PH_SIZE;
        end
        PH_SIZE: begin
          if (size_cnt >= SIZE_CNT_W'(MAX_SIZE_BYTES)) begin
            first_err_next = ST_LENGTH;
          end else begin
            size_acc_next = {size_acc[SIZE_W-8:0], byte_in[6:0]};
            size_cnt_next = size_cnt + SIZE_CNT_W'(1);
            if (!byte_in[7]) phase_next = PH_ID_HI;
          end
        end
        default: begin
          // payload byte: counted even after a soft error
          if (payload_cnt != PAYLOAD_MAX) payload_cnt_next = payload_cnt + PAYLOAD_W'(1);
          if (first_err == ST_OK) begin
            unique case (phase)
              PH_ID_HI: begin
                id_reg_next = {byte_in, 8'd0};
                phase_next  = PH_ID_LO;
              end
              PH_ID_LO: begin
                id_reg_next = {id_reg[15:8], id_reg[7:0] | byte_in};
                phase_next  = PH_FLAGS;
              end
              PH_FLAGS: begin
                if (byte_in != 8'd0) first_err_next = ST_FLAGS;
                else phase_next = PH_DC_TAG;
              end
              PH_DC_TAG: begin
                if (byte_in != tags.dc) first_err_next = ST_NO_DC;
                else phase_next = PH_DC_LEN;
              end
              PH_DC_LEN: begin
                dc_len_next   = {1'b0, byte_in} + 9'd2;
                skip_rem_next = {1'b0, byte_in};
                phase_next    = (byte_in != 8'd0) ? PH_DC_SKIP : PH_SL_TAG;
              end
              PH_DC_SKIP: begin
                skip_rem_next = skip_dec;
                if (skip_dec == 9'd0) phase_next = PH_SL_TAG;
              end
              PH_SL_TAG: begin
                if (byte_in != tags.sl) first_err_next = ST_NO_SL;
                else phase_next = PH_SL_LEN;
              end
              PH_SL_LEN: begin
                sl_len_next   = {1'b0, byte_in} + 9'd2;
                skip_rem_next = {1'b0, byte_in};
                phase_next    = (byte_in != 8'd0) ? PH_SL_SKIP : PH_TRAIL;
              end
              PH_SL_SKIP: begin
                skip_rem_next = skip_dec;
                if (skip_dec == 9'd0) phase_next = PH_TRAIL;
              end
              default: junk_next = 1'b1;
            endcase
          end
        end
      endcase
    end
  end

  // final status, from the state after this byte
  always_comb begin
    if ((first_err_next == ST_BAD_TAG) || (first_err_next == ST_LENGTH))
      status_next = first_err_next;
    else if ((phase_next == PH_TAG) || (phase_next == PH_SIZE))
      status_next = ST_TRUNCATED;
    else if (payload_cnt_next != {1'b0, size_acc_next})
      status_next = ST_LENGTH;
    else if (first_err_next != ST_OK)
      status_next = first_err_next;
    else if (phase_next != PH_TRAIL)
      status_next = ST_TRUNCATED;
    else
      status_next = ST_OK;
  end

  assign res.status               = status_next;
  assign res.stream_id            = id_reg_next;
  assign res.decoder_config_bytes = dc_len_next;
  assign res.sl_config_bytes      = sl_len_next;
  assign res.junk_at_end          = junk_next;
  assign res.declared_length      = size_acc_next;
  assign res_valid                = take && last_byte;

  // frame state; the last byte returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      phase       <= PH_TAG;
      size_acc    <= '0;
      size_cnt    <= '0;
      payload_cnt <= '0;
      id_reg      <= '0;
      skip_rem    <= '0;
      first_err   <= ST_OK;
      dc_len      <= '0;
      sl_len      <= '0;
      junk        <= 1'b0;
    end else begin
      phase       <= phase_next;
      size_acc    <= size_acc_next;
      size_cnt    <= size_cnt_next;
      payload_cnt <= payload_cnt_next;
      id_reg      <= id_reg_next;
      skip_rem    <= skip_rem_next;
      first_err   <= first_err_next;
      dc_len      <= dc_len_next;
      sl_len      <= sl_len_next;
      junk        <= junk_next;
    end
  end

endmodule

`default_nettype wire

[design/es_descriptor_frame_checker_top.sv]
// ----------------------------------------------------------------------------
// es_descriptor_frame_checker_top
// Checks the framing of an ES descriptor, one byte per beat, one result per
// descriptor.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry byte_in and last_byte, one byte of
// the descriptor per beat; last_byte marks the final byte of a descriptor.
// Output channel: out_valid / out_stall carry one result beat per descriptor
// (status, stream_id, sub-descriptor sizes, junk_at_end, declared_length).
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data sets the
// three expected tags; cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle while in_stall is low. The result is formed
// from the last accepted byte and registered in the result register, or in
// the skid register while out_stall holds the result register full.
// A result register plus a skid register sit at the output: while a result
// waits under out_stall, further bytes are still accepted, and in_stall rises
// only once a second result is parked in the skid register.
// Reset (rst, synchronous): frame state cleared, tags back to 3 / 4 / 6, both
// output registers emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module es_descriptor_frame_checker_top
  import es_dfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // byte input
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        byte_in,
  input  wire logic              last_byte,
  // result output
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [15:0]            stream_id,
  output logic [8:0]             decoder_config_bytes,
  output logic [8:0]             sl_config_bytes,
  output logic                   junk_at_end,
  output logic [SIZE_W-1:0]      declared_length,
  // configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  tags_t tags;
  logic  take;
  logic  res_valid;
  res_t  res;
  res_t  out_q;
  res_t  skid_q;
  logic  skid_valid;
  logic  out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // tag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tags.es <= ES_TAG_RESET;
      tags.dc <= DC_TAG_RESET;
      tags.sl <= SL_TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ES_TAG: tags.es <= cfg_data;
        REG_DC_TAG: tags.dc <= cfg_data;
        REG_SL_TAG: tags.sl <= cfg_data;
        default: ;
      endcase
    end
  end

  es_dfc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .byte_in   (byte_in),
    .last_byte (last_byte),
    .tags      (tags),
    .res_valid (res_valid),
    .res       (res)
  );

  // output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign status               = out_q.status;
  assign stream_id            = out_q.stream_id;
  assign decoder_config_bytes = out_q.decoder_config_bytes;
  assign sl_config_bytes      = out_q.sl_config_bytes;
  assign junk_at_end          = out_q.junk_at_end;
  assign declared_length      = out_q.declared_length;

endmodule

`default_nettype wire

[design/es_dfc_checker.sv]
// ----------------------------------------------------------------------------
// es_dfc_checker
// Port-level checks of the ES descriptor frame checker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module es_dfc_checker
  import es_dfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic              last_byte,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [2:0]        status,
  input  wire logic [8:0]        decoder_config_bytes,
  input  wire logic [8:0]        sl_config_bytes
);

  // a stalled result beat stays up with the same status
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result beat dropped or changed");

  // after the last byte of a descriptor a result beat is up next cycle, its own or an older stalled one
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_byte |=> out_valid)
    else $error("no result after last byte");

  // a middle byte never makes a result appear
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_byte && !(out_valid && out_stall) |=> !out_valid)
    else $error("result without last byte");

  // a clean descriptor has seen both sub-descriptors
  a_ok_sizes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |->
      (decoder_config_bytes >= 9'd2) && (sl_config_bytes >= 9'd2))
    else $error("ok status without both sub-descriptors");

endmodule

bind es_descriptor_frame_checker_top es_dfc_checker u_es_dfc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .last_byte            (last_byte),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .status               (status),
  .decoder_config_bytes (decoder_config_bytes),
  .sl_config_bytes      (sl_config_bytes)
);

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ES descriptor frame checker. Byte beats come
// from a queue, and a cycle-level parser model predicts one verdict per
// descriptor. Each verdict on the result port is compared field by field.
// The run covers directed framing corners and then well-formed descriptors
// with random content, mixed with corrupted and truncated ones. It uses
// four tag settings and varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import es_dfc_pkg::*;

  // parser phases of the prediction
  typedef enum logic [3:0] {
    FR_TAG, FR_SIZE, FR_ID_HI, FR_ID_LO, FR_FLAGS, FR_DC_TAG, FR_DC_LEN,
    FR_DC_SKIP, FR_SL_TAG, FR_SL_LEN, FR_SL_SKIP, FR_TRAIL
  } frame_phase_e;

  // flavors of generated descriptors
  typedef enum {
    DK_GOOD, DK_JUNK, DK_BAD_TAG, DK_SIZE_OFF, DK_FLAGS, DK_NO_DC, DK_NO_SL,
    DK_CUT, DK_SIZE_OVER, DK_HUGE, DK_NOISE
  } desc_kind_e;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } byte_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        byte_in = 8'h00;
  logic              last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [15:0]       stream_id;
  logic [8:0]        decoder_config_bytes;
  logic [8:0]        sl_config_bytes;
  logic              junk_at_end;
  logic [SIZE_W-1:0] declared_length;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_ES_TAG;
  logic [7:0]        cfg_data = 8'h00;

  es_descriptor_frame_checker_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .byte_in(byte_in), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .stream_id(stream_id),
    .decoder_config_bytes(decoder_config_bytes),
    .sl_config_bytes(sl_config_bytes),
    .junk_at_end(junk_at_end), .declared_length(declared_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus side
  byte_beat_t  beat_q[$];
  int unsigned stim_beats = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_took = 1'b0;
  logic [7:0]  set_es = ES_TAG_RESET;
  logic [7:0]  set_dc = DC_TAG_RESET;
  logic [7:0]  set_sl = SL_TAG_RESET;

  // predicted verdicts, oldest first
  res_t        frame_verdicts[$];
  int unsigned mismatches = 0;

  // parser model: tag copies and frame state
  logic [7:0]           model_es, model_dc, model_sl;
  frame_phase_e         fr_phase;
  logic [SIZE_W-1:0]    size_acc;
  logic [SIZE_CNT_W-1:0] size_cnt;
  logic [PAYLOAD_W-1:0] payload_cnt;
  logic [15:0]          id_reg;
  logic [8:0]           skip_left;
  logic [2:0]           err_code;
  logic [8:0]           dc_bytes;
  logic [8:0]           sl_bytes;
  logic                 trailing;

  // directed opening, {last, byte}
  logic [8:0] opening [0:23] = '{
    // minimal good descriptor, id ffff, empty sub-descriptors
    9'h003, 9'h007, 9'h0ff, 9'h0ff, 9'h000, 9'h004, 9'h000, 9'h006, 9'h100,
    // lone wrong tag
    9'h1ff,
    // ends on the tag
    9'h103,
    // ends inside the size field
    9'h003, 9'h180,
    // a fifth size byte
    9'h003, 9'h080, 9'h080, 9'h080, 9'h080, 9'h100,
    // largest declared size, nothing after it
    9'h003, 9'h0ff, 9'h0ff, 9'h0ff, 9'h17f
  };

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [27:0] got,
                               input logic [27:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic clear_frame_state();
    fr_phase    = FR_TAG;
    size_acc    = '0;
    size_cnt    = '0;
    payload_cnt = '0;
    id_reg      = '0;
    skip_left   = '0;
    err_code    = ST_OK;
    dc_bytes    = '0;
    sl_bytes    = '0;
    trailing    = 1'b0;
  endtask

  // advance the parser model by one accepted byte; close the frame on last
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    res_t v;
    if (err_code != ST_BAD_TAG && err_code != ST_LENGTH) begin
      case (fr_phase)
        FR_TAG: begin
          if (b != model_es) err_code = ST_BAD_TAG;
          else fr_phase = FR_SIZE;
        end
        FR_SIZE: begin
          if (size_cnt >= MAX_SIZE_BYTES) begin
            err_code = ST_LENGTH;
          end else begin
            size_acc = {size_acc[SIZE_W-8:0], b[6:0]};
            size_cnt++;
            if (!b[7]) fr_phase = FR_ID_HI;
          end
        end
        default: begin
          // every byte after the size field counts as payload
          if (payload_cnt != {PAYLOAD_W{1'b1}}) payload_cnt++;
          if (err_code == ST_OK) begin
            case (fr_phase)
              FR_ID_HI: begin
                id_reg   = {b, 8'h00};
                fr_phase = FR_ID_LO;
              end
              FR_ID_LO: begin
                id_reg[7:0] = b;
                fr_phase    = FR_FLAGS;
              end
              FR_FLAGS: begin
                if (b != 8'h00) err_code = ST_FLAGS;
                else fr_phase = FR_DC_TAG;
              end
              FR_DC_TAG: begin
                if (b != model_dc) err_code = ST_NO_DC;
                else fr_phase = FR_DC_LEN;
              end
              FR_DC_LEN: begin
                dc_bytes  = 9'd2 + b;
                skip_left = {1'b0, b};
                fr_phase  = (b != 8'h00) ? FR_DC_SKIP : FR_SL_TAG;
              end
              FR_DC_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) fr_phase = FR_SL_TAG;
              end
              FR_SL_TAG: begin
                if (b != model_sl) err_code = ST_NO_SL;
                else fr_phase = FR_SL_LEN;
              end
              FR_SL_LEN: begin
                sl_bytes  = 9'd2 + b;
                skip_left = {1'b0, b};
                fr_phase  = (b != 8'h00) ? FR_SL_SKIP : FR_TRAIL;
              end
              FR_SL_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) fr_phase = FR_TRAIL;
              end
              default: trailing = 1'b1;
            endcase
          end
        end
      endcase
    end
    if (last) begin
      // status priority: framing error, short header, size, first error, end
      if (err_code == ST_BAD_TAG || err_code == ST_LENGTH) v.status = err_code;
      else if (fr_phase == FR_TAG || fr_phase == FR_SIZE) v.status = ST_TRUNCATED;
      else if (payload_cnt != {1'b0, size_acc}) v.status = ST_LENGTH;
      else if (err_code != ST_OK) v.status = err_code;
      else if (fr_phase != FR_TRAIL) v.status = ST_TRUNCATED;
      else v.status = ST_OK;
      v.stream_id            = id_reg;
      v.decoder_config_bytes = dc_bytes;
      v.sl_config_bytes      = sl_bytes;
      v.junk_at_end          = trailing;
      v.declared_length      = size_acc;
      frame_verdicts.push_back(v);
      clear_frame_state();
    end
  endtask

  // sample handshakes at the rising edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      in_took <= 1'b0;
      model_es = ES_TAG_RESET;
      model_dc = DC_TAG_RESET;
      model_sl = SL_TAG_RESET;
      clear_frame_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ES_TAG: model_es = cfg_data;
          REG_DC_TAG: model_dc = cfg_data;
          REG_SL_TAG: model_sl = cfg_data;
          default: ;
        endcase
      end
      // result beat
      if (out_valid && !out_stall) begin
        if (frame_verdicts.size() == 0) begin
          report_mismatch("result beat with no verdict pending");
        end else begin
          want = frame_verdicts.pop_front();
          compare_field("status", status, want.status);
          compare_field("stream_id", stream_id, want.stream_id);
          compare_field("decoder_config_bytes", decoder_config_bytes,
                        want.decoder_config_bytes);
          compare_field("sl_config_bytes", sl_config_bytes, want.sl_config_bytes);
          compare_field("junk_at_end", junk_at_end, want.junk_at_end);
          compare_field("declared_length", declared_length, want.declared_length);
        end
      end
      // byte beat
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) absorb_byte(byte_in, last_byte);
    end
  end

  // byte driver, falling edge
  always @(negedge clk) begin : driver
    byte_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = beat_q.pop_front();
        in_valid  <= 1'b1;
        byte_in   <= nxt.value;
        last_byte <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic push_beat(input logic [7:0] value, input logic last);
    byte_beat_t bt;
    bt.value = value;
    bt.last  = last;
    beat_q.push_back(bt);
    stim_beats++;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] v);
    return v + 8'($urandom_range(1, 255));
  endfunction

  // sub-descriptor length: mostly short, now and then long
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 95) return $urandom_range(1, 6);
    if (r < 98) return $urandom_range(7, 254);
    return 255;
  endfunction

  // build one descriptor of a random flavor and queue its bytes
  task automatic queue_descriptor();
    logic [7:0]  body[$];
    logic [7:0]  frame[$];
    logic [27:0] decl;
    int unsigned roll, dc_len, sl_len, n_groups, n_size, n_keep;
    desc_kind_e  kind;
    roll = $urandom_range(99);
    if (roll < 45) kind = DK_GOOD;
    else if (roll < 50) kind = DK_JUNK;
    else if (roll < 56) kind = DK_BAD_TAG;
    else if (roll < 62) kind = DK_SIZE_OFF;
    else if (roll < 68) kind = DK_FLAGS;
    else if (roll < 74) kind = DK_NO_DC;
    else if (roll < 80) kind = DK_NO_SL;
    else if (roll < 88) kind = DK_CUT;
    else if (roll < 92) kind = DK_SIZE_OVER;
    else if (roll < 96) kind = DK_HUGE;
    else kind = DK_NOISE;

    if (kind == DK_NOISE) begin
      repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
    end else begin
      // payload: id, flags, decoder config, sl config, optional trailer
      body.push_back(8'($urandom));
      body.push_back(8'($urandom));
      if (kind == DK_FLAGS || (kind == DK_SIZE_OFF && $urandom_range(1) == 1))
        body.push_back(8'($urandom_range(1, 255)));
      else
        body.push_back(8'h00);
      body.push_back(kind == DK_NO_DC ? other_than(set_dc) : set_dc);
      dc_len = pick_len();
      body.push_back(8'(dc_len));
      repeat (dc_len) body.push_back(8'($urandom));
      body.push_back(kind == DK_NO_SL ? other_than(set_sl) : set_sl);
      sl_len = pick_len();
      body.push_back(8'(sl_len));
      repeat (sl_len) body.push_back(8'($urandom));
      if (kind == DK_JUNK) repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));

      // declared size
      decl = 28'(body.size());
      if (kind == DK_SIZE_OFF)
        decl = ($urandom_range(1) == 1) ? decl + 28'd1 : decl - 28'd1;
      n_groups = 1 + (decl >= 28'd128) + (decl >= 28'd16384) + (decl >= 28'd2097152);
      n_size = ($urandom_range(3) == 0) ? $urandom_range(n_groups, MAX_SIZE_BYTES)
                                         : n_groups;
      if (kind == DK_HUGE) begin
        decl   = 28'($urandom);
        n_size = MAX_SIZE_BYTES;
      end

      frame.push_back(kind == DK_BAD_TAG ? other_than(set_es) : set_es);
      if (kind == DK_SIZE_OVER) begin
        repeat (MAX_SIZE_BYTES) frame.push_back(8'h80 | 8'($urandom_range(127)));
        frame.push_back(8'($urandom));
      end else begin
        for (int i = n_size - 1; i >= 0; i--)
          frame.push_back({i != 0, 7'(decl >> (7 * i))});
      end
      foreach (body[i]) frame.push_back(body[i]);
    end

    n_keep = (kind == DK_CUT) ? $urandom_range(1, frame.size() - 1) : frame.size();
    for (int i = 0; i < n_keep; i++) push_beat(frame[i], i == n_keep - 1);
  endtask

  // wait for all bytes taken and all verdicts seen, then let the pipe settle
  task automatic wait_drained();
    while (beat_q.size() != 0 || in_valid || frame_verdicts.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tag(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ES_TAG: set_es = value;
      REG_DC_TAG: set_dc = value;
      REG_SL_TAG: set_sl = value;
      default: ;
    endcase
  endtask

  task automatic run_random(input int unsigned n_beats);
    int unsigned target;
    target = stim_beats + n_beats;
    while (stim_beats < target) queue_descriptor();
    wait_drained();
  endtask

  // main sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset tags, directed corners
    send_gap_pct   = 30;
    recv_stall_pct = 88;
    foreach (opening[i]) push_beat(opening[i][7:0], opening[i][8]);
    wait_drained();

    // low extremes, slow receiver
    write_tag(REG_ES_TAG, 8'h00);
    write_tag(REG_DC_TAG, 8'hff);
    write_tag(REG_SL_TAG, 8'h80);
    run_random(450);

    // high extremes, slow sender
    send_gap_pct   = 88;
    recv_stall_pct = 30;
    write_tag(REG_ES_TAG, 8'hff);
    write_tag(REG_DC_TAG, 8'h00);
    write_tag(REG_SL_TAG, 8'hff);
    run_random(450);

    // random tags, full rate
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_tag(REG_ES_TAG, 8'($urandom));
    write_tag(REG_DC_TAG, 8'($urandom));
    write_tag(REG_SL_TAG, 8'($urandom));
    run_random(450);

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // hang guard
  initial begin
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
design/es_dfc_pkg.sv
design/es_dfc_parser.sv
design/es_descriptor_frame_checker_top.sv
design/es_dfc_checker.sv
verif/tb_top.sv
